>>> rtl/core/adm_pkg.sv
// Shared types and constants for the arcade drive mixer with slew limit.
package adm_pkg;

  localparam int unsigned AXIS_W  = 8;
  localparam int unsigned SPEED_W = 8;
  localparam int unsigned DZ_W    = 7;
  localparam int unsigned CFG_W   = 8;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned MAG_W   = 7;
  localparam int unsigned PROD_W  = 15;
  localparam int unsigned DIV_STEPS = PROD_W;
  localparam int unsigned STEP_CNT_W = 4;

  localparam logic [AXIS_W-1:0] CENTRE    = 8'd127;
  localparam logic [AXIS_W-1:0] SPAN_MAX  = 8'd254;
  localparam logic [MAG_W-1:0]  SPEED_LIM = 7'd127;

  localparam logic [DZ_W-1:0]  DEADZONE_RESET  = 7'd10;
  localparam logic [CFG_W-1:0] NUMERATOR_RESET = 8'd3;
  localparam logic [CFG_W-1:0] DENOM_RESET     = 8'd4;
  localparam logic [CFG_W-1:0] ACCEL_RESET     = 8'd10;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEADZONE_WIDTH    = 2'd0,
    REG_SCALE_NUMERATOR   = 2'd1,
    REG_SCALE_DENOMINATOR = 2'd2,
    REG_ACCEL_RATE        = 2'd3
  } reg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MIX,
    ST_LOAD,
    ST_DIVIDE,
    ST_SLEW
  } state_t;

  typedef struct packed {
    logic capture;
    logic mix;
    logic load_div;
    logic div_step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic scale_en;
  } status_t;

endpackage

>>> rtl/core/adm_if.sv
// Stream interfaces for joystick samples and motor commands.
interface adm_in_if;
  logic                          valid;
  logic                          ready;
  logic [adm_pkg::AXIS_W-1:0]    stick_y;
  logic [adm_pkg::AXIS_W-1:0]    stick_x;
  logic                          dz_enable;
  logic                          turbo_pressed;
  logic                          gear_high;

  modport source (output valid, stick_y, stick_x, dz_enable, turbo_pressed, gear_high,
                  input ready);
  modport sink (input valid, stick_y, stick_x, dz_enable, turbo_pressed, gear_high,
                output ready);
endinterface

interface adm_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [adm_pkg::SPEED_W-1:0] left_speed;
  logic signed [adm_pkg::SPEED_W-1:0] right_speed;
  logic                               gear_out;

  modport source (output valid, left_speed, right_speed, gear_out, input ready);
  modport sink (input valid, left_speed, right_speed, gear_out, output ready);
endinterface

>>> rtl/core/arcade_drive_mixer_slew_limit_unit.sv
// Arcade drive mixer with slew limit: a sample is mixed, then, in high gear without turbo,
// scaled by the ratio in two lanes of a 15-step restoring divider, before the slew step.
// A new sample is taken only once the last one has been written to the output register.
// A finished result waits in the output register while the next sample is taken.
// Reset: deadzone 10, ratio 3/4, accel rate 10, previous speeds 0, no result pending.
module arcade_drive_mixer_slew_limit_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [adm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [adm_pkg::CFG_W-1:0]       cfg_data,
  adm_in_if.sink                          sample,
  adm_out_if.source                       result
);

  adm_pkg::cmd_t    cmd;
  adm_pkg::status_t status;

  adm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sample.valid),
    .in_ready  (sample.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .status    (status),
    .cmd       (cmd)
  );

  adm_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .stick_y       (sample.stick_y),
    .stick_x       (sample.stick_x),
    .dz_enable     (sample.dz_enable),
    .turbo_pressed (sample.turbo_pressed),
    .gear_high     (sample.gear_high),
    .cmd           (cmd),
    .status        (status),
    .left_speed    (result.left_speed),
    .right_speed   (result.right_speed),
    .gear_out      (result.gear_out)
  );

endmodule

>>> rtl/core/adm_ctrl.sv
// Sequencing controller: accept, mix, divide, slew and output handshake.
module adm_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  adm_pkg::status_t status,
  output adm_pkg::cmd_t    cmd
);

  adm_pkg::state_t                   state, state_next;
  logic [adm_pkg::STEP_CNT_W-1:0]    step_cnt, step_cnt_next;
  logic                              out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= adm_pkg::ST_IDLE;
      step_cnt  <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      step_cnt  <= step_cnt_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    step_cnt_next  = step_cnt;
    cmd            = '0;
    in_ready       = 1'b0;
    out_valid_next = out_valid && !out_ready;
    unique case (state)
      adm_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = adm_pkg::ST_MIX;
        end
      end
      adm_pkg::ST_MIX: begin
        cmd.mix    = 1'b1;
        state_next = status.scale_en ? adm_pkg::ST_LOAD : adm_pkg::ST_SLEW;
      end
      adm_pkg::ST_LOAD: begin
        cmd.load_div  = 1'b1;
        step_cnt_next = '0;
        state_next    = adm_pkg::ST_DIVIDE;
      end
      adm_pkg::ST_DIVIDE: begin
        cmd.div_step  = 1'b1;
        step_cnt_next = step_cnt + 1'b1;
        if (step_cnt == adm_pkg::STEP_CNT_W'(adm_pkg::DIV_STEPS - 1)) begin
          state_next = adm_pkg::ST_SLEW;
        end
      end
      adm_pkg::ST_SLEW: begin
        if (!out_valid || out_ready) begin
          cmd.finish     = 1'b1;
          out_valid_next = 1'b1;
          state_next     = adm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = adm_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/core/adm_datapath.sv
// Datapath: config registers, mixer, serial dividers, slew limiter, output registers.
module adm_datapath (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_wr_en,
  input  logic [adm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [adm_pkg::CFG_W-1:0]          cfg_data,
  input  logic [adm_pkg::AXIS_W-1:0]         stick_y,
  input  logic [adm_pkg::AXIS_W-1:0]         stick_x,
  input  logic                               dz_enable,
  input  logic                               turbo_pressed,
  input  logic                               gear_high,
  input  adm_pkg::cmd_t                      cmd,
  output adm_pkg::status_t                   status,
  output logic signed [adm_pkg::SPEED_W-1:0] left_speed,
  output logic signed [adm_pkg::SPEED_W-1:0] right_speed,
  output logic                               gear_out
);

  logic [adm_pkg::DZ_W-1:0]   dz_width;
  logic [adm_pkg::CFG_W-1:0]  numerator;
  logic [adm_pkg::CFG_W-1:0]  denominator;
  logic [adm_pkg::CFG_W-1:0]  accel;

  logic [adm_pkg::AXIS_W-1:0] y_reg, x_reg;
  logic                       dz_reg, turbo_reg, high_reg;

  logic signed [adm_pkg::SPEED_W-1:0] left_mix, right_mix;
  logic signed [adm_pkg::SPEED_W-1:0] left_prev, right_prev;
  logic [adm_pkg::CFG_W-1:0]          den_eff;
  logic [adm_pkg::PROD_W-1:0]         dvd_l, dvd_r;
  logic [adm_pkg::CFG_W-1:0]          rem_l, rem_r;

  logic [adm_pkg::AXIS_W-1:0]         y_dz, x_dz;
  logic signed [adm_pkg::SPEED_W-1:0] left_mix_next, right_mix_next;
  logic [adm_pkg::PROD_W-1:0]         dvd_l_next, dvd_r_next;
  logic [adm_pkg::CFG_W-1:0]          rem_l_next, rem_r_next;
  logic signed [adm_pkg::SPEED_W-1:0] left_want, right_want;
  logic signed [adm_pkg::SPEED_W-1:0] left_slew, right_slew;

  function automatic logic [adm_pkg::AXIS_W-1:0] deadzone(
    input logic [adm_pkg::AXIS_W-1:0] v,
    input logic [adm_pkg::DZ_W-1:0]   w,
    input logic                       en
  );
    logic [adm_pkg::AXIS_W:0] lo_sum;
    logic [adm_pkg::AXIS_W:0] hi_sum;
    lo_sum = {1'b0, v} + {2'b00, w};
    hi_sum = {1'b0, adm_pkg::CENTRE} + {2'b00, w};
    if (en && (lo_sum > {1'b0, adm_pkg::CENTRE}) && ({1'b0, v} < hi_sum)) begin
      return adm_pkg::CENTRE;
    end
    return v;
  endfunction

  function automatic logic signed [adm_pkg::SPEED_W-1:0] clamp_recentre(
    input logic signed [adm_pkg::AXIS_W+1:0] v
  );
    logic [adm_pkg::AXIS_W-1:0] c;
    if (v < 0) begin
      c = '0;
    end else if (v > $signed({2'b00, adm_pkg::SPAN_MAX})) begin
      c = adm_pkg::SPAN_MAX;
    end else begin
      c = v[adm_pkg::AXIS_W-1:0];
    end
    return adm_pkg::SPEED_W'(c - adm_pkg::CENTRE);
  endfunction

  function automatic logic [adm_pkg::PROD_W-1:0] product(
    input logic signed [adm_pkg::SPEED_W-1:0] s,
    input logic [adm_pkg::CFG_W-1:0]          num
  );
    logic [adm_pkg::SPEED_W-1:0] neg;
    logic [adm_pkg::MAG_W-1:0]   mag;
    neg = adm_pkg::SPEED_W'(-s);
    mag = s[adm_pkg::SPEED_W-1] ? neg[adm_pkg::MAG_W-1:0] : s[adm_pkg::MAG_W-1:0];
    return adm_pkg::PROD_W'(mag) * adm_pkg::PROD_W'(num);
  endfunction

  function automatic logic [adm_pkg::PROD_W+adm_pkg::CFG_W-1:0] div_step(
    input logic [adm_pkg::PROD_W-1:0] dvd,
    input logic [adm_pkg::CFG_W-1:0]  rem,
    input logic [adm_pkg::CFG_W-1:0]  den
  );
    logic [adm_pkg::CFG_W:0] shifted;
    logic [adm_pkg::CFG_W:0] diff;
    shifted = {rem, dvd[adm_pkg::PROD_W-1]};
    diff    = shifted - {1'b0, den};
    if (shifted >= {1'b0, den}) begin
      return {dvd[adm_pkg::PROD_W-2:0], 1'b1, diff[adm_pkg::CFG_W-1:0]};
    end
    return {dvd[adm_pkg::PROD_W-2:0], 1'b0, shifted[adm_pkg::CFG_W-1:0]};
  endfunction

  function automatic logic signed [adm_pkg::SPEED_W-1:0] saturate(
    input logic [adm_pkg::PROD_W-1:0] q,
    input logic                       neg
  );
    logic [adm_pkg::MAG_W-1:0] m;
    m = (q > adm_pkg::PROD_W'(adm_pkg::SPEED_LIM)) ? adm_pkg::SPEED_LIM
                                                   : q[adm_pkg::MAG_W-1:0];
    return neg ? adm_pkg::SPEED_W'(-$signed({1'b0, m})) : adm_pkg::SPEED_W'({1'b0, m});
  endfunction

  function automatic logic signed [adm_pkg::SPEED_W-1:0] slew(
    input logic signed [adm_pkg::SPEED_W-1:0] want,
    input logic signed [adm_pkg::SPEED_W-1:0] prev,
    input logic [adm_pkg::CFG_W-1:0]          rate
  );
    logic signed [adm_pkg::SPEED_W+1:0] w;
    logic signed [adm_pkg::SPEED_W+1:0] p;
    logic signed [adm_pkg::SPEED_W+1:0] r;
    logic signed [adm_pkg::SPEED_W+1:0] res;
    w = 10'(want);
    p = 10'(prev);
    r = $signed({2'b00, rate});
    if (w + r < p) begin
      res = p - r;
    end else if (w - r > p) begin
      res = p + r;
    end else begin
      res = w;
    end
    return res[adm_pkg::SPEED_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      dz_width    <= adm_pkg::DEADZONE_RESET;
      numerator   <= adm_pkg::NUMERATOR_RESET;
      denominator <= adm_pkg::DENOM_RESET;
      accel       <= adm_pkg::ACCEL_RESET;
    end else if (cfg_wr_en) begin
      unique case (adm_pkg::reg_index_t'(cfg_index))
        adm_pkg::REG_DEADZONE_WIDTH:    dz_width    <= cfg_data[adm_pkg::DZ_W-1:0];
        adm_pkg::REG_SCALE_NUMERATOR:   numerator   <= cfg_data;
        adm_pkg::REG_SCALE_DENOMINATOR: denominator <= cfg_data;
        adm_pkg::REG_ACCEL_RATE:        accel       <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    y_dz = deadzone(y_reg, dz_width, dz_reg);
    x_dz = deadzone(x_reg, dz_width, dz_reg);
    right_mix_next = clamp_recentre($signed({2'b00, y_dz}) + $signed({2'b00, x_dz})
                                    - $signed({2'b00, adm_pkg::CENTRE}));
    left_mix_next  = clamp_recentre($signed({2'b00, y_dz}) - $signed({2'b00, x_dz})
                                    + $signed({2'b00, adm_pkg::CENTRE}));
    {dvd_l_next, rem_l_next} = div_step(dvd_l, rem_l, den_eff);
    {dvd_r_next, rem_r_next} = div_step(dvd_r, rem_r, den_eff);
    left_want  = status.scale_en ? saturate(dvd_l, left_mix[adm_pkg::SPEED_W-1])  : left_mix;
    right_want = status.scale_en ? saturate(dvd_r, right_mix[adm_pkg::SPEED_W-1]) : right_mix;
    left_slew  = slew(left_want, left_prev, accel);
    right_slew = slew(right_want, right_prev, accel);
  end

  assign status.scale_en = high_reg && !turbo_reg;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      y_reg     <= stick_y;
      x_reg     <= stick_x;
      dz_reg    <= dz_enable;
      turbo_reg <= turbo_pressed;
      high_reg  <= gear_high;
    end
    if (cmd.mix) begin
      left_mix  <= left_mix_next;
      right_mix <= right_mix_next;
    end
    if (cmd.load_div) begin
      dvd_l   <= product(left_mix, numerator);
      dvd_r   <= product(right_mix, numerator);
      rem_l   <= '0;
      rem_r   <= '0;
      den_eff <= (denominator == '0) ? adm_pkg::CFG_W'(1) : denominator;
    end else if (cmd.div_step) begin
      dvd_l <= dvd_l_next;
      dvd_r <= dvd_r_next;
      rem_l <= rem_l_next;
      rem_r <= rem_r_next;
    end
    if (cmd.finish) begin
      left_speed  <= left_slew;
      right_speed <= right_slew;
      gear_out    <= high_reg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_prev  <= '0;
      right_prev <= '0;
    end else if (cmd.finish) begin
      left_prev  <= left_slew;
      right_prev <= right_slew;
    end
  end

endmodule
